// ----- hdl/pcmn_pkg.sv -----
package pcmn_pkg;

    // Field and register widths
    localparam int SAMPLE_W       = 16;
    localparam int MAG_W          = SAMPLE_W + 1;
    localparam int TARGET_W       = 15;
    localparam int GAIN_W         = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int PROD_W         = MAG_W + GAIN_W;
    localparam int ROUND_W        = PROD_W - GAIN_FRAC_BITS;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = GAIN_W;

    // Restoring divider: one quotient bit per step
    localparam int DIVD_W    = TARGET_W + GAIN_FRAC_BITS;
    localparam int DIV_STEPS = DIVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Constants
    localparam logic [GAIN_W-1:0]     UNITY_GAIN  = GAIN_W'(1 << GAIN_FRAC_BITS);
    localparam logic [GAIN_W:0]       UNITY_CMP   = (GAIN_W+1)'(1 << GAIN_FRAC_BITS);
    localparam logic [TARGET_W-1:0]   TARGET_RST  = TARGET_W'(29490);
    localparam logic [GAIN_W-1:0]     MAX_GAIN_RST = GAIN_W'(655360);
    localparam logic [ROUND_W-1:0]    POS_LIMIT   = ROUND_W'(32767);
    localparam logic [ROUND_W-1:0]    NEG_LIMIT   = ROUND_W'(32768);
    localparam logic [PROD_W-1:0]     ROUND_HALF  = PROD_W'(1 << (GAIN_FRAC_BITS - 1));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN = 1'b1;

    // Item and result codes
    localparam logic OP_MEASURE    = 1'b0;
    localparam logic OP_APPLY      = 1'b1;
    localparam logic KIND_REPORT   = 1'b0;
    localparam logic KIND_SAMPLE   = 1'b1;

    typedef enum logic [1:0] {
        ST_SCALED  = 2'd0,
        ST_UNITY   = 2'd1,
        ST_SILENCE = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic meas;       // fold the input word into the peak
        logic apply;      // register magnitude times gain
        logic div_init;   // load dividend, clear remainder
        logic div_step;   // one quotient bit
        logic div_fin;    // cap, classify, update gain and status
        logic load_rep;   // load a report into the output register
        logic load_smp;   // load a processed sample into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic peak_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/pcmn_ctrl.sv -----
module pcmn_ctrl
    import pcmn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    input  logic i_last,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHK  = 6'b000010,
        S_DIV  = 6'b000100,
        S_FIN  = 6'b001000,
        S_REP  = 6'b010000,
        S_SMP  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_MEASURE) begin
                        o_cmd.meas = 1'b1;
                        if (i_last) n_state = S_CHK;
                    end else begin
                        o_cmd.apply = 1'b1;
                        n_state     = S_SMP;
                    end
                end
            end
            S_CHK: begin
                o_cmd.div_init = 1'b1;
                n_state = i_sts.peak_zero ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state = S_REP;
            end
            S_REP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_rep = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SMP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_smp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register is only written when it can take the word
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_rep || o_cmd.load_smp) |-> i_sts.out_free)
        else $error("output load while output register busy");

    // Gain computation only follows an accepted last measure word
    a_chk_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> $past(accept && i_op == OP_MEASURE && i_last))
        else $error("gain computation without a last measure word");

endmodule

// ----- hdl/pcmn_dp.sv -----
module pcmn_dp
    import pcmn_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_first,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic                        o_kind,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    output logic [1:0]                  o_status,
    output logic [GAIN_W-1:0]           o_gain_out
);

    // Configuration and measured state
    logic [TARGET_W-1:0]  r_target;
    logic [GAIN_W-1:0]    r_max_gain;
    logic [SAMPLE_W-1:0]  r_peak;
    logic [GAIN_W-1:0]    r_gain;
    t_status              r_status;

    // Divider
    logic [SAMPLE_W-1:0]  r_rem;
    logic [DIVD_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Apply stage
    logic [PROD_W-1:0]    r_prod;
    logic                 r_neg;
    logic [SAMPLE_W-1:0]  r_raw;

    // Output register
    logic                 r_ov;
    logic                 r_kind;
    logic [SAMPLE_W-1:0]  r_sample_out;
    t_status              r_status_o;
    logic [GAIN_W-1:0]    r_gain_o;

    logic [MAG_W-1:0]     mag;
    logic [SAMPLE_W-1:0]  peak_base;
    logic [MAG_W-1:0]     trial;
    logic                 trial_ge;
    logic [MAG_W-1:0]     trial_sub;
    logic [GAIN_W-1:0]    g_cap;
    logic [PROD_W-1:0]    rounded_sum;
    logic [ROUND_W-1:0]   rmag;
    logic [SAMPLE_W-1:0]  scaled;
    logic [SAMPLE_W-1:0]  smp_word;

    // Magnitude of the incoming sample; the most negative value gives 32768
    assign mag       = i_sample[SAMPLE_W-1] ? (MAG_W'(1 << SAMPLE_W) - {1'b0, i_sample})
                                            : {1'b0, i_sample};
    assign peak_base = i_first ? '0 : r_peak;

    // Restoring division step
    assign trial     = {r_rem, r_quo[DIVD_W-1]};
    assign trial_ge  = (trial >= {1'b0, r_peak});
    assign trial_sub = trial - {1'b0, r_peak};

    // Cap the quotient at the gain ceiling
    assign g_cap = (r_quo > DIVD_W'(r_max_gain)) ? r_max_gain : r_quo[GAIN_W-1:0];

    // Round half away from zero on the magnitude, then saturate
    assign rounded_sum = r_prod + ROUND_HALF;
    assign rmag        = rounded_sum[PROD_W-1:GAIN_FRAC_BITS];
    always_comb begin
        if (r_neg) begin
            scaled = (rmag > NEG_LIMIT) ? SAMPLE_W'(NEG_LIMIT)
                                        : SAMPLE_W'(NEG_LIMIT) - rmag[SAMPLE_W-1:0]
                                          + SAMPLE_W'(NEG_LIMIT);
        end else begin
            scaled = (rmag > POS_LIMIT) ? SAMPLE_W'(POS_LIMIT) : rmag[SAMPLE_W-1:0];
        end
    end
    assign smp_word = (r_status == ST_SCALED) ? scaled : r_raw;

    assign o_sts.peak_zero = (r_peak == '0);
    assign o_sts.div_done  = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free  = !r_ov || !i_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RST;
            r_max_gain <= MAX_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET:   r_target   <= i_cfg_data[TARGET_W-1:0];
                REG_MAX_GAIN: r_max_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Peak, gain and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak   <= '0;
            r_gain   <= UNITY_GAIN;
            r_status <= ST_SILENCE;
        end else begin
            if (i_cmd.meas) begin
                r_peak <= (mag[SAMPLE_W-1:0] > peak_base || mag[SAMPLE_W])
                          ? mag[SAMPLE_W-1:0] : peak_base;
            end
            if (i_cmd.div_fin) begin
                if (r_peak == '0) begin
                    r_status <= ST_SILENCE;
                    r_gain   <= UNITY_GAIN;
                end else if ({1'b0, g_cap} <= UNITY_CMP) begin
                    r_status <= ST_UNITY;
                    r_gain   <= UNITY_GAIN;
                end else begin
                    r_status <= ST_SCALED;
                    r_gain   <= g_cap;
                end
            end
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= {r_target, {GAIN_FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIVD_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Multiply magnitude by the gain
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_prod <= {{(PROD_W-MAG_W){1'b0}}, mag} * {{(PROD_W-GAIN_W){1'b0}}, r_gain};
            r_neg  <= i_sample[SAMPLE_W-1];
            r_raw  <= i_sample;
        end
    end

    // Output register: hold the word while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_rep || i_cmd.load_smp) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rep || i_cmd.load_smp) begin
            r_kind       <= i_cmd.load_smp ? KIND_SAMPLE : KIND_REPORT;
            r_sample_out <= i_cmd.load_smp ? smp_word : '0;
            r_status_o   <= r_status;
            r_gain_o     <= r_gain;
        end
    end

    assign o_valid      = r_ov;
    assign o_kind       = r_kind;
    assign o_sample_out = r_sample_out;
    assign o_status     = r_status_o;
    assign o_gain_out   = r_gain_o;

    // Unity and silence always carry the unity gain
    a_unity_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_SCALED) |-> (r_gain == UNITY_GAIN))
        else $error("gain not unity outside scaled status");

    // Scaled status carries a gain above unity
    a_scaled_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == ST_SCALED) |-> ({1'b0, r_gain} > UNITY_CMP))
        else $error("scaled status with gain at or below unity");

endmodule

// ----- hdl/pcm16_peak_normalizer.sv -----
// Channel | Direction | Handshake          | Word
// --------+-----------+--------------------+-------------------------------------
// input   | in        | i_valid / o_stall  | i_op, i_sample, i_first, i_last
// output  | out       | o_valid / i_stall  | o_kind, o_sample_out, o_status, o_gain_out
// config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Measure word without last: folded into the peak as it is accepted. Measure word
// with last: the restoring divider produces one gain bit per cycle (31 steps).
// Apply word: multiplier register, then round and saturate into the output register.
// Reset is synchronous, active low; peak clears, gain is unity, status silence.
// A finished word waits in the output register while stalled; the block takes
// no new word until the current one is done and its result, if any, is loaded.
module pcm16_peak_normalizer
    import pcmn_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_first,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_kind,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    output logic [1:0]                  o_status,
    output logic [GAIN_W-1:0]           o_gain_out,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    pcmn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_last  (i_last),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pcmn_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_sample),
        .i_first      (i_first),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_sample_out (o_sample_out),
        .o_status     (o_status),
        .o_gain_out   (o_gain_out)
    );

endmodule

// ----- tb/sv/pcmn_checker.sv -----
`timescale 1ns / 100ps

module pcmn_checker
    import pcmn_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_op,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_first,
    input  logic                        i_last,
    // output channel
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_kind,
    input  logic signed [SAMPLE_W-1:0]  i_sample_out,
    input  logic [1:0]                  i_status,
    input  logic [GAIN_W-1:0]           i_gain_out,
    // register writes
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] smp;
        t_status                    status;
        logic [GAIN_W-1:0]          gain;
    } t_norm_word;

    // Shadow of the block's state and registers
    logic [MAG_W-1:0]    peak_mag;
    logic [GAIN_W-1:0]   gain_q;
    t_status             status_q;
    logic [TARGET_W-1:0] target_q;
    logic [GAIN_W-1:0]   gain_cap_q;

    t_norm_word pending_words[$];
    int         fails = 0;

    // Multiply by the gain, round half away from zero, clamp to 16 bits
    function automatic logic [SAMPLE_W-1:0] scale_by_gain(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [GAIN_W-1:0]          gain
    );
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [PROD_W:0]  prod;
        logic [PROD_W:0]  rnd;
        logic [MAG_W-1:0] twos;
        neg  = smp[SAMPLE_W-1];
        mag  = neg ? ((MAG_W'(1) << SAMPLE_W) - {1'b0, smp}) : {1'b0, smp};
        prod = mag * gain;
        rnd  = (prod + ((PROD_W+1)'(1) << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
        if (neg) begin
            if (rnd > 32768) rnd = 32768;
            twos = (MAG_W'(1) << SAMPLE_W) - rnd[MAG_W-1:0];
            return twos[SAMPLE_W-1:0];
        end
        if (rnd > 32767) rnd = 32767;
        return rnd[SAMPLE_W-1:0];
    endfunction

    // Advance the shadow state by one accepted word, queue what it produces
    task automatic normalize_word(
        input logic                       op,
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       first,
        input logic                       last
    );
        logic [MAG_W-1:0] mag;
        logic [63:0]      quot;
        t_norm_word       w;
        mag = smp[SAMPLE_W-1] ? ((MAG_W'(1) << SAMPLE_W) - {1'b0, smp}) : {1'b0, smp};
        if (op == OP_MEASURE) begin
            if (first) peak_mag = '0;
            if (mag > peak_mag) peak_mag = mag;
            if (last) begin
                if (peak_mag == 0) begin
                    status_q = ST_SILENCE;
                    gain_q   = UNITY_GAIN;
                end else begin
                    quot = (64'(target_q) << GAIN_FRAC_BITS) / 64'(peak_mag);
                    if (quot > 64'(gain_cap_q)) quot = 64'(gain_cap_q);
                    // at or below 1.0 the block passes samples through
                    if (quot <= (64'(1) << GAIN_FRAC_BITS)) begin
                        status_q = ST_UNITY;
                        gain_q   = UNITY_GAIN;
                    end else begin
                        status_q = ST_SCALED;
                        gain_q   = quot[GAIN_W-1:0];
                    end
                end
                w.kind   = KIND_REPORT;
                w.smp    = '0;
                w.status = status_q;
                w.gain   = gain_q;
                pending_words.push_back(w);
            end
        end else begin
            w.kind   = KIND_SAMPLE;
            w.smp    = (status_q == ST_SCALED) ? scale_by_gain(smp, gain_q) : smp;
            w.status = status_q;
            w.gain   = gain_q;
            pending_words.push_back(w);
        end
    endtask

    // Compare output words, then fold in the input word of the same edge
    always @(posedge i_clk) begin : watch
        t_norm_word exp_w;
        if (!i_rst_n) begin
            peak_mag   = '0;
            gain_q     = UNITY_GAIN;
            status_q   = ST_SILENCE;
            target_q   = TARGET_RST;
            gain_cap_q = MAX_GAIN_RST;
            pending_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected word: kind=%0d smp=%0d status=%0d gain=%06h",
                                 i_kind, i_sample_out, i_status, i_gain_out);
                    fails++;
                end else begin
                    exp_w = pending_words.pop_front();
                    if (i_kind !== exp_w.kind || i_sample_out !== exp_w.smp ||
                        i_status !== exp_w.status || i_gain_out !== exp_w.gain) begin
                        if (fails < 10) begin
                            $display("mismatch: expected kind=%0d smp=%0d status=%0d gain=%06h",
                                     exp_w.kind, exp_w.smp, exp_w.status, exp_w.gain);
                            $display("          got      kind=%0d smp=%0d status=%0d gain=%06h",
                                     i_kind, i_sample_out, i_status, i_gain_out);
                        end
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                normalize_word(i_op, i_sample, i_first, i_last);
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_TARGET)
                    target_q = i_cfg_data[TARGET_W-1:0];
                else if (i_cfg_idx == REG_MAX_GAIN)
                    gain_cap_q = i_cfg_data[GAIN_W-1:0];
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_words.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import pcmn_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_WORDS    = 200;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_TAIL     = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic                       o_stall;
    logic                       i_op         = OP_MEASURE;
    logic signed [SAMPLE_W-1:0] i_sample     = '0;
    logic                       i_first      = 1'b0;
    logic                       i_last       = 1'b0;
    logic                       o_valid;
    logic                       i_stall      = 1'b0;
    logic                       o_kind;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic [1:0]                 o_status;
    logic [GAIN_W-1:0]          o_gain_out;
    logic                       i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx    = REG_TARGET;
    logic [CFG_DATA_W-1:0]      i_cfg_data   = '0;

    int fail_count;
    int pending;
    int words_sent   = 0;
    int idle_cycles  = 0;
    bit idle_on      = 1'b1;
    bit hold_req     = 1'b0;

    pcm16_peak_normalizer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_sample     (i_sample),
        .i_first      (i_first),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_sample_out (o_sample_out),
        .o_status     (o_status),
        .o_gain_out   (o_gain_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    pcmn_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_op         (i_op),
        .i_sample     (i_sample),
        .i_first      (i_first),
        .i_last       (i_last),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_kind       (o_kind),
        .i_sample_out (o_sample_out),
        .i_status     (o_status),
        .i_gain_out   (o_gain_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output side: random stall bursts, one long hold-off on request
    always begin : recv_ctl
        int unsigned run_len;
        logic        stall_val;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req  = 1'b0;
                stall_val = 1'b1;
                run_len   = LONG_HOLD;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_val = 1'b1;
                run_len   = $urandom_range(1, 18);
            end else begin
                stall_val = 1'b0;
                run_len   = idle_on ? $urandom_range(1, 30) : 1;
            end
            i_stall <= stall_val;
            repeat (run_len) @(negedge i_clk);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one word, hold it until accepted; starts and ends at a falling edge
    task automatic send_word(
        input logic                       op,
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       first,
        input logic                       last
    );
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_sample <= smp;
        i_first  <= first;
        i_last   <= last;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Stop offering and wait out every outstanding result
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    // Drain, then write both level registers; junk above the target width
    task automatic set_levels(input logic [TARGET_W-1:0] tgt, input logic [GAIN_W-1:0] cap);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TARGET;
        i_cfg_data <= {(CFG_DATA_W-TARGET_W)'($urandom), tgt};
        @(negedge i_clk);
        i_cfg_idx  <= REG_MAX_GAIN;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random sample limited to 'bits' of signed range, extremes now and then
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned bits);
        logic signed [SAMPLE_W-1:0] r;
        r = SAMPLE_W'($urandom);
        if (bits == 0) return '0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return r >>> (SAMPLE_W - bits);
    endfunction

    // One measure pass then one apply pass, or a single noise word
    task automatic random_block();
        int unsigned n_meas;
        int unsigned n_apply;
        int unsigned bits;
        logic        drop_last;
        if ($urandom_range(0, 7) == 0) begin
            send_word(1'($urandom), SAMPLE_W'($urandom), 1'($urandom), 1'($urandom));
        end else begin
            bits      = $urandom_range(0, 16);
            n_meas    = $urandom_range(1, 24);
            drop_last = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < n_meas; i++)
                send_word(OP_MEASURE, pick_sample(bits), i == 0,
                          (i == n_meas - 1) && !drop_last);
            n_apply = $urandom_range(1, 24);
            for (int i = 0; i < n_apply; i++)
                send_word(OP_APPLY, pick_sample($urandom_range(8, 16)),
                          1'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = words_sent;
        while (words_sent - start < count) random_block();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // apply before any measure pass: silence, pass through, flags ignored
        send_word(OP_APPLY, 16'sh7FFF, 1'b1, 1'b1);
        send_word(OP_APPLY, 16'sh8000, 1'b1, 1'b0);
        send_word(OP_APPLY, 16'sh0000, 1'b0, 1'b1);
        // most negative sample counts as 32768: gain below one, unity
        send_word(OP_MEASURE, 16'sh8000, 1'b1, 1'b0);
        send_word(OP_MEASURE, 16'sd100, 1'b0, 1'b1);
        send_word(OP_APPLY, 16'sh8000, 1'b0, 1'b0);
        send_word(OP_APPLY, 16'sd12345, 1'b0, 1'b0);
        // first and last together on a zero peak: silence
        send_word(OP_MEASURE, 16'sh0000, 1'b1, 1'b1);
        send_word(OP_APPLY, -16'sd1, 1'b0, 1'b0);
        // peak of one: gain capped at the ceiling
        send_word(OP_MEASURE, 16'sd1, 1'b1, 1'b0);
        send_word(OP_MEASURE, -16'sd1, 1'b0, 1'b1);
        send_word(OP_APPLY, 16'sh7FFF, 1'b0, 1'b0);
        send_word(OP_APPLY, 16'sh8000, 1'b0, 1'b0);
        send_word(OP_APPLY, 16'sd1, 1'b0, 1'b0);
        send_word(OP_APPLY, -16'sd1, 1'b0, 1'b0);
        send_word(OP_APPLY, 16'sd0, 1'b0, 1'b0);
        send_word(OP_APPLY, 16'sd3277, 1'b0, 1'b0);
        send_word(OP_APPLY, -16'sd3277, 1'b0, 1'b0);
        // mid-level peak: fractional gain, rounding and saturation
        send_word(OP_MEASURE, 16'sd16384, 1'b1, 1'b1);
        send_word(OP_APPLY, 16'sd16384, 1'b0, 1'b0);
        send_word(OP_APPLY, -16'sd16383, 1'b0, 1'b0);
        send_word(OP_APPLY, 16'sh7FFF, 1'b0, 1'b0);
        send_word(OP_APPLY, 16'sd12345, 1'b0, 1'b0);

        // reset levels
        run_random(PHASE_WORDS);

        // full target, no ceiling; block fills up behind a long output hold
        set_levels(15'h7FFF, 24'hFFFFFF);
        hold_req = 1'b1;
        run_random(PHASE_WORDS);

        // zero target: every pass ends in unity or silence
        set_levels(15'h0000, 24'hFFFFFF);
        run_random(PHASE_WORDS);

        // zero ceiling
        set_levels(15'h7FFF, 24'h000000);
        run_random(PHASE_WORDS);

        // random levels, sender pause mid-phase
        set_levels(TARGET_W'($urandom), GAIN_W'($urandom));
        run_random(PHASE_WORDS / 2);
        drain();
        run_random(PHASE_WORDS / 2);

        // ceiling just above unity
        set_levels(15'd16384, 24'h010001);
        run_random(PHASE_WORDS);

        set_levels(TARGET_W'($urandom_range(1, 64)), GAIN_W'($urandom));
        run_random(PHASE_WORDS);

        // last part: no idling on either side
        set_levels(TARGET_W'($urandom), GAIN_W'($urandom_range(65536, 24'hFFFFFF)));
        idle_on = 1'b0;
        run_random(PHASE_WORDS);

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
